// ===== hw/rtl/vpid_pkg.sv =====
// Package: shared types, command codes and saturation helpers for the velocity PID unit
`timescale 1ns / 1ps
`default_nettype none
package vpid_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_TC        = 3'd1,
        REG_TI        = 3'd2,
        REG_TD        = 3'd3,
        REG_ETA       = 3'd4,
        REG_GAIN_NUM  = 3'd5,
        REG_GAIN_DEN  = 3'd6
    } t_reg_idx;

    // Input operation codes
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] set_point;
        logic signed [15:0] measured;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] delta_output;
        logic               fault;
    } t_out_beat;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PREP,
        ST_INT_MUL,
        ST_INT_START,
        ST_INT_WAIT,
        ST_DER_CHK,
        ST_ETA_START,
        ST_ETA_WAIT,
        ST_TDE_START,
        ST_TDE_WAIT,
        ST_NUM,
        ST_DER_MUL,
        ST_DER_START,
        ST_DER_WAIT,
        ST_SUM1,
        ST_SUM2,
        ST_GAIN_MUL,
        ST_GAIN_START,
        ST_GAIN_WAIT,
        ST_DONE
    } t_state;

    // Datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_PREP,
        DP_INT_MUL,
        DP_INT_START,
        DP_INT_ZERO,
        DP_INT_WAIT,
        DP_ETA_START,
        DP_ETA_WAIT,
        DP_TDE_START,
        DP_TDE_WAIT,
        DP_NUM,
        DP_DER_MUL,
        DP_DER_ZERO,
        DP_DER_SAT,
        DP_DER_START,
        DP_DER_WAIT,
        DP_SUM1,
        DP_SUM2,
        DP_GAIN_MUL,
        DP_GAIN_SAT,
        DP_GAIN_START,
        DP_GAIN_WAIT,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic ti_zero;
        logic td_zero;
        logic eta_zero;
        logic dvs_zero;
        logic gd_zero;
        logic out_busy;
    } t_dp_sts;

    localparam logic signed [33:0] MAX32 = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] MIN32 = -34'sh0_8000_0000;
    localparam logic signed [33:0] MAX16 = 34'sh0_0000_7FFF;
    localparam logic signed [33:0] MIN16 = -34'sh0_0000_8000;

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
        return t[31:0];
    endfunction

    function automatic logic f_ovf32(input logic signed [33:0] v);
        return (v > MAX32) || (v < MIN32);
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v > MAX16) ? MAX16 : ((v < MIN16) ? MIN16 : v);
        return t[15:0];
    endfunction

    function automatic logic f_ovf16(input logic signed [33:0] v);
        return (v > MAX16) || (v < MIN16);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vpid_div.sv =====
// Iterative restoring divider: signed 32-bit dividend by nonzero unsigned 16-bit divisor
`timescale 1ns / 1ps
`default_nettype none
module vpid_div
    import vpid_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_dividend,
    input  wire logic        [15:0] i_divisor,
    output logic signed [31:0]      o_quot,
    output logic                    o_done
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_q, n_q;
    logic        r_neg, n_neg;
    logic [15:0] r_dvs, n_dvs;
    logic [16:0] w_sh;
    logic        w_ge;
    logic [16:0] w_diff;

    // One quotient bit per cycle
    always_comb begin
        w_sh   = {r_rem, r_q[31]};
        w_ge   = (w_sh >= {1'b0, r_dvs});
        w_diff = w_sh - {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_neg  = r_neg;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_neg  = i_dividend[31];
            n_q    = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[15:0] : w_sh[15:0];
            n_q   = {r_q[30:0], w_ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_neg <= n_neg;
        r_dvs <= n_dvs;
    end

    // Restore the sign of the quotient
    assign o_quot = r_neg ? (32'sd0 - $signed(r_q)) : $signed(r_q);
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/vpid_ctrl.sv =====
// Controller: sequences one sample through the datapath
`timescale 1ns / 1ps
`default_nettype none
module vpid_ctrl
    import vpid_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_op,
    input  wire t_dp_sts i_sts,
    output logic         o_idle,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (i_in_valid) begin
                               n_state = (i_in_op == OP_CLEAR) ? ST_CLEAR : ST_PREP;
                           end
            ST_CLEAR:      n_state = ST_DONE;
            ST_PREP:       n_state = ST_INT_MUL;
            ST_INT_MUL:    n_state = ST_INT_START;
            ST_INT_START:  n_state = i_sts.ti_zero ? ST_DER_CHK : ST_INT_WAIT;
            ST_INT_WAIT:   if (i_sts.div_done) n_state = ST_DER_CHK;
            ST_DER_CHK: begin
                if (i_sts.td_zero)       n_state = ST_SUM1;
                else if (i_sts.eta_zero) n_state = ST_NUM;
                else                     n_state = ST_ETA_START;
            end
            ST_ETA_START:  n_state = ST_ETA_WAIT;
            ST_ETA_WAIT:   if (i_sts.div_done) n_state = ST_TDE_START;
            ST_TDE_START:  n_state = ST_TDE_WAIT;
            ST_TDE_WAIT:   if (i_sts.div_done) n_state = ST_NUM;
            ST_NUM:        n_state = ST_DER_MUL;
            ST_DER_MUL:    n_state = ST_DER_START;
            ST_DER_START:  n_state = i_sts.dvs_zero ? ST_SUM1 : ST_DER_WAIT;
            ST_DER_WAIT:   if (i_sts.div_done) n_state = ST_SUM1;
            ST_SUM1:       n_state = ST_SUM2;
            ST_SUM2:       n_state = ST_GAIN_MUL;
            ST_GAIN_MUL:   n_state = ST_GAIN_START;
            ST_GAIN_START: n_state = i_sts.gd_zero ? ST_DONE : ST_GAIN_WAIT;
            ST_GAIN_WAIT:  if (i_sts.div_done) n_state = ST_DONE;
            ST_DONE:       if (!i_sts.out_busy) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd.op = DP_NOP;
        case (r_state)
            ST_IDLE:       if (i_in_valid) o_cmd.op = DP_LOAD;
            ST_CLEAR:      o_cmd.op = DP_CLEAR;
            ST_PREP:       o_cmd.op = DP_PREP;
            ST_INT_MUL:    o_cmd.op = DP_INT_MUL;
            ST_INT_START:  o_cmd.op = i_sts.ti_zero ? DP_INT_ZERO : DP_INT_START;
            ST_INT_WAIT:   o_cmd.op = DP_INT_WAIT;
            ST_DER_CHK:    if (i_sts.td_zero) o_cmd.op = DP_DER_ZERO;
            ST_ETA_START:  o_cmd.op = DP_ETA_START;
            ST_ETA_WAIT:   o_cmd.op = DP_ETA_WAIT;
            ST_TDE_START:  o_cmd.op = DP_TDE_START;
            ST_TDE_WAIT:   o_cmd.op = DP_TDE_WAIT;
            ST_NUM:        o_cmd.op = DP_NUM;
            ST_DER_MUL:    o_cmd.op = DP_DER_MUL;
            ST_DER_START:  o_cmd.op = i_sts.dvs_zero ? DP_DER_SAT : DP_DER_START;
            ST_DER_WAIT:   o_cmd.op = DP_DER_WAIT;
            ST_SUM1:       o_cmd.op = DP_SUM1;
            ST_SUM2:       o_cmd.op = DP_SUM2;
            ST_GAIN_MUL:   o_cmd.op = DP_GAIN_MUL;
            ST_GAIN_START: o_cmd.op = i_sts.gd_zero ? DP_GAIN_SAT : DP_GAIN_START;
            ST_GAIN_WAIT:  o_cmd.op = DP_GAIN_WAIT;
            ST_DONE:       if (!i_sts.out_busy) o_cmd.op = DP_OUT_LOAD;
            default:       o_cmd.op = DP_NOP;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/vpid_dp.sv =====
// Datapath: registers, state, multiplier, shared divider and output register
`timescale 1ns / 1ps
`default_nettype none
module vpid_dp
    import vpid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire t_in_beat    i_in,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    output logic             o_valid,
    output t_out_beat        o_out,
    input  wire logic        i_stall
);

    // Configuration
    logic [1:0]  r_mode;
    logic [14:0] r_tc, r_ti, r_td, r_eta, r_kn, r_kd;

    // Sample state
    t_in_beat           r_in;
    logic signed [15:0] r_eh [3];
    logic signed [15:0] r_mh [3];
    logic signed [31:0] r_dprev;
    logic               r_fault;

    // Working registers
    logic signed [31:0] r_prod;
    logic signed [31:0] r_integ;
    logic signed [31:0] r_q;
    logic        [15:0] r_tde;
    logic signed [15:0] r_num16;
    logic        [15:0] r_dvs;
    logic signed [31:0] r_deriv;
    logic signed [31:0] r_acc;
    logic signed [15:0] r_d16;
    logic signed [15:0] r_res;
    logic               r_ovalid;
    t_out_beat          r_out;

    logic               w_direct, w_pidd;
    logic signed [15:0] w_pv;
    logic signed [33:0] w_diff;
    logic signed [15:0] w_e0;
    logic signed [15:0] w_h0, w_h1, w_h2;
    logic signed [33:0] w_num, w_numq;
    logic signed [31:0] w_num32;
    logic signed [33:0] w_num_fin;
    logic signed [33:0] w_sum1, w_sum2;
    logic signed [31:0] w_sum2_32;
    logic signed [15:0] w_mul_a;
    logic        [14:0] w_mul_b;
    logic signed [31:0] w_mul;
    logic               w_div_start;
    logic signed [31:0] w_div_a;
    logic        [15:0] w_div_b;
    logic signed [31:0] w_quot;
    logic               w_div_done;
    logic               w_fault_set;

    assign w_direct = r_mode[0];
    assign w_pidd   = r_mode[1];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_tc   <= '0;
            r_ti   <= '0;
            r_td   <= '0;
            r_eta  <= '0;
            r_kn   <= 15'd1;
            r_kd   <= 15'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:     r_mode <= i_cfg_data[1:0];
                REG_TC:       r_tc   <= i_cfg_data;
                REG_TI:       r_ti   <= i_cfg_data;
                REG_TD:       r_td   <= i_cfg_data;
                REG_ETA:      r_eta  <= i_cfg_data;
                REG_GAIN_NUM: r_kn   <= i_cfg_data;
                REG_GAIN_DEN: r_kd   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Error and measured value of the new sample
    always_comb begin
        w_pv = r_in.measured;
        if (w_pidd && !w_direct && (r_in.measured == -16'sd32768)) begin
            w_pv = -16'sd32767;
        end
        w_diff = w_direct ? (34'(w_pv) - 34'(r_in.set_point))
                          : (34'(r_in.set_point) - 34'(w_pv));
        w_e0 = f_sat16(w_diff);
    end

    // Second difference plus filter feedback
    always_comb begin
        w_h0 = w_pidd ? r_mh[0] : r_eh[0];
        w_h1 = w_pidd ? r_mh[1] : r_eh[1];
        w_h2 = w_pidd ? r_mh[2] : r_eh[2];
        w_num     = 34'(w_h0) - (34'(w_h1) <<< 1) + 34'(w_h2);
        w_numq    = w_num + 34'(r_q);
        w_num32   = f_sat32(w_numq);
        w_num_fin = (r_eta == '0) ? w_num : 34'(w_num32);
    end

    // Sums toward the velocity step
    always_comb begin
        w_sum1    = 34'(r_eh[0]) - 34'(r_eh[1]) + 34'(r_integ);
        w_sum2    = 34'(r_acc) + 34'(r_deriv);
        w_sum2_32 = f_sat32(w_sum2);
    end

    // Shared multiplier
    always_comb begin
        case (i_cmd.op)
            DP_INT_MUL: begin
                w_mul_a = r_eh[0];
                w_mul_b = r_tc;
            end
            DP_DER_MUL: begin
                w_mul_a = r_num16;
                w_mul_b = r_td;
            end
            default: begin
                w_mul_a = r_d16;
                w_mul_b = r_kn;
            end
        endcase
        w_mul = 32'(w_mul_a) * $signed({17'd0, w_mul_b});
    end

    // Shared divider operands
    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = r_prod;
        w_div_b     = {1'b0, r_kd};
        case (i_cmd.op)
            DP_INT_START: begin
                w_div_start = 1'b1;
                w_div_b     = {1'b0, r_ti};
            end
            DP_ETA_START: begin
                w_div_start = 1'b1;
                w_div_a     = r_dprev;
                w_div_b     = {1'b0, r_eta};
            end
            DP_TDE_START: begin
                w_div_start = 1'b1;
                w_div_a     = {17'd0, r_td};
                w_div_b     = {1'b0, r_eta};
            end
            DP_DER_START: begin
                w_div_start = 1'b1;
                w_div_b     = r_dvs;
            end
            DP_GAIN_START: begin
                w_div_start = 1'b1;
            end
            default: w_div_start = 1'b0;
        endcase
    end

    vpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // Collect saturation and zero-divisor events
    always_comb begin
        w_fault_set = 1'b0;
        case (i_cmd.op)
            DP_PREP: w_fault_set = f_ovf16(w_diff) ||
                                   (w_pidd && !w_direct && (r_in.measured == -16'sd32768));
            DP_NUM:  w_fault_set = ((r_eta != '0) && f_ovf32(w_numq)) ||
                                   f_ovf16(w_num_fin);
            DP_DER_SAT:   w_fault_set = 1'b1;
            DP_SUM1:      w_fault_set = f_ovf32(w_sum1);
            DP_SUM2:      w_fault_set = f_ovf32(w_sum2) || f_ovf16(34'(w_sum2_32));
            DP_GAIN_SAT:  w_fault_set = 1'b1;
            DP_GAIN_WAIT: w_fault_set = w_div_done && f_ovf16(34'(w_quot));
            default:      w_fault_set = 1'b0;
        endcase
    end

    // Control state: fault latch and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_CLEAR) begin
                r_fault <= 1'b0;
            end else if (w_fault_set) begin
                r_fault <= 1'b1;
            end
            if (i_cmd.op == DP_OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // History and derivative memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_eh[i] <= '0;
                r_mh[i] <= '0;
            end
            r_dprev <= '0;
        end else begin
            case (i_cmd.op)
                DP_CLEAR: begin
                    for (int i = 0; i < 3; i++) begin
                        r_eh[i] <= '0;
                        r_mh[i] <= '0;
                    end
                    r_dprev <= '0;
                end
                DP_PREP: begin
                    r_eh[2] <= r_eh[1];
                    r_eh[1] <= r_eh[0];
                    r_eh[0] <= w_e0;
                    if (w_pidd) begin
                        r_mh[2] <= r_mh[1];
                        r_mh[1] <= r_mh[0];
                        r_mh[0] <= w_direct ? w_pv : (16'sd0 - w_pv);
                    end
                end
                DP_DER_ZERO: r_dprev <= '0;
                DP_DER_SAT: begin
                    r_dprev <= (r_prod < 0) ? 32'sh8000_0000
                             : ((r_prod > 0) ? 32'sh7FFF_FFFF : 32'sd0);
                end
                DP_DER_WAIT: if (w_div_done) r_dprev <= w_quot;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD:     r_in <= i_in;
            DP_CLEAR:    r_res <= '0;
            DP_INT_MUL,
            DP_DER_MUL,
            DP_GAIN_MUL: r_prod <= w_mul;
            DP_INT_ZERO: r_integ <= '0;
            DP_INT_WAIT: if (w_div_done) r_integ <= w_quot;
            DP_ETA_WAIT: if (w_div_done) r_q <= w_quot;
            DP_TDE_WAIT: if (w_div_done) r_tde <= w_quot[15:0];
            DP_NUM: begin
                r_num16 <= f_sat16(w_num_fin);
                r_dvs   <= {1'b0, r_tc} + ((r_eta == '0) ? {1'b0, r_td} : r_tde);
            end
            DP_DER_ZERO: r_deriv <= '0;
            DP_DER_SAT: begin
                r_deriv <= (r_prod < 0) ? 32'sh8000_0000
                         : ((r_prod > 0) ? 32'sh7FFF_FFFF : 32'sd0);
            end
            DP_DER_WAIT: if (w_div_done) r_deriv <= w_quot;
            DP_SUM1:     r_acc <= f_sat32(w_sum1);
            DP_SUM2:     r_d16 <= f_sat16(34'(w_sum2_32));
            DP_GAIN_SAT: begin
                r_res <= (r_prod < 0) ? -16'sd32768
                       : ((r_prod > 0) ? 16'sd32767 : 16'sd0);
            end
            DP_GAIN_WAIT: if (w_div_done) r_res <= f_sat16(34'(w_quot));
            DP_OUT_LOAD: begin
                r_out.delta_output <= r_res;
                r_out.fault        <= r_fault;
            end
            default: ;
        endcase
    end

    // Status toward the controller
    always_comb begin
        o_sts.div_done = w_div_done;
        o_sts.ti_zero  = (r_ti == '0);
        o_sts.td_zero  = (r_td == '0);
        o_sts.eta_zero = (r_eta == '0);
        o_sts.dvs_zero = (r_dvs == '0);
        o_sts.gd_zero  = (r_kd == '0);
        o_sts.out_busy = r_ovalid && i_stall;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/velocity_pid_incomplete_derivative_unit.sv =====
// Top level: velocity-form PID with incomplete derivative, controller plus datapath
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-----------------------------------
//   input    | in        | i_valid / o_stall      | t_in_beat  (op, set_point, measured)
//   output   | out       | o_valid / i_stall      | t_out_beat (delta_output, fault)
//   config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// After accept, a clear passes through ST_CLEAR to ST_DONE, which loads its result. A
// control step walks its controller states and runs the shared radix-2 divider once
// for each divide it needs (up to five) before ST_DONE loads its result. The next beat
// can be accepted in the cycle after the result is loaded. Reset is synchronous and
// active low; it clears history, fault and registers to their reset values. A finished
// result waits in the output register under i_stall while the block is idle and accepts
// the next beat; a second result waits in the last state until then.
`timescale 1ns / 1ps
`default_nettype none
module velocity_pid_incomplete_derivative_unit
    import vpid_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_beat    i_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_beat        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_idle;

    vpid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_in_op    (i_in.op),
        .i_sts      (w_sts),
        .o_idle     (w_idle),
        .o_cmd      (w_cmd)
    );

    vpid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_stall     (i_stall)
    );

    assign o_stall     = !w_idle;
    assign o_cfg_ready = 1'b1;

    // An accepted beat closes the input until its result is done
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input still open after accept");

    // A result appears only at the end of work on an item
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without an item in work");

    // The result of a clear reports no fault
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_in.op == OP_CLEAR)) |=> ##2
        (!o_out.fault || !o_valid || $past(o_valid)))
        else $error("clear result carries a fault");

endmodule
`default_nettype wire
